/* design/terminal_line_editor_unit_assert.svh */
// Assertion macros shared by the line editor RTL.
`ifndef TERMINAL_LINE_EDITOR_UNIT_ASSERT_SVH
`define TERMINAL_LINE_EDITOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TLE_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TLE_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/tle_pkg.sv */
// Types and constants shared by the line editor modules.
`default_nettype none

package tle_pkg;

  // Character codes
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_SP  = 8'h20;

  // Register index of echo_enable (address bit 2)
  localparam logic REG_IDX_ECHO = 1'b0;

  // Command queue
  localparam int Q_DEPTH = 4;
  localparam int QAW     = 2;
  localparam int CMD_AW  = 8;

  typedef enum logic [1:0] {
    REQ_CHAR = 2'd0,
    REQ_POP  = 2'd1,
    REQ_LINE = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_POP  = 2'd1,
    KIND_LINE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    OP_ECHO       = 3'd0,
    OP_RUBOUT     = 3'd1,
    OP_POP        = 3'd2,
    OP_POP_EMPTY  = 3'd3,
    OP_LINE       = 3'd4,
    OP_LINE_EMPTY = 3'd5
  } op_t;

  // One classified item as handed from front to back
  typedef struct packed {
    op_t                op;
    logic [7:0]         ch;
    logic [CMD_AW-1:0]  addr;
    logic [5:0]         n;
    logic               lr;
    logic [5:0]         blen;
  } tle_cmd_t;

  // Back end status seen by the front end
  typedef struct packed {
    logic idle;
    logic rd_done;
  } tle_back_stat_t;

endpackage

`default_nettype wire

/* design/tle_in_if.sv */
// Request channel interface of the line editor.
`default_nettype none

interface tle_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] in_char;
  logic [6:0] max_chars;

  modport source (output valid, req_type, in_char, max_chars, input ready);
  modport sink   (input valid, req_type, in_char, max_chars, output ready);
endinterface

`default_nettype wire

/* design/tle_out_if.sv */
// Result channel interface of the line editor.
`default_nettype none

interface tle_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_char;
  logic       out_valid;
  logic       last;
  logic [5:0] line_count;
  logic       line_ready;
  logic [5:0] buffered_len;

  modport source (output valid, out_kind, out_char, out_valid, last, line_count,
                  line_ready, buffered_len, input ready);
  modport sink   (input valid, out_kind, out_char, out_valid, last, line_count,
                  line_ready, buffered_len, output ready);
endinterface

`default_nettype wire

/* design/terminal_line_editor_unit.sv */
// Top level of the cooked-mode line editor.
//
//  port group  dir   handshake          payload
//  in_if       in    valid/ready        req_type, in_char, max_chars
//  out_if      out   valid/ready        out_kind .. buffered_len
//  cfg_*       in    APB write/read     echo_enable at byte address 0
//
// A received character or rubout is accepted without waiting for its echo;
// its echo results leave one per cycle while out_if is ready (three for a
// rubout) from the result register. Pop and take-line use the single read
// port of the line memory: the first character passes the command queue,
// the RAM read register and the result register, then one per cycle while
// out_if is ready, and no new item is accepted until the last read is done.
// Reset is synchronous; the memory is not cleared. A stalled result holds the
// back end; the command queue (4 deep) holds the front end only when full.
`default_nettype none
`include "terminal_line_editor_unit_assert.svh"

module terminal_line_editor_unit #(
  parameter int RING_SIZE = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  tle_in_if.sink           in_if,
  tle_out_if.source        out_if,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  import tle_pkg::*;

  localparam int AW = $clog2(RING_SIZE);

  logic           echo_r, echo_nxt;
  logic           q_full, q_empty, q_push, q_pop;
  tle_cmd_t       q_cmd, q_head;
  tle_back_stat_t back_stat;
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [7:0]     mem_wdata, mem_rdata;
  logic           rd_busy;
  logic           cfg_wr;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_IDX_ECHO);
  assign echo_nxt   = cfg_wr ? cfg_pwdata[0] : echo_r;
  assign cfg_prdata = (cfg_paddr[2] == REG_IDX_ECHO) ? {31'd0, echo_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_r <= 1'b0;
    end else begin
      echo_r <= echo_nxt;
    end
  end

  tle_front #(.RING_SIZE(RING_SIZE)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .echo_en   (echo_r),
    .in_if     (in_if),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd),
    .back_stat (back_stat),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .rd_busy   (rd_busy)
  );

  tle_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  tle_ram #(.WIDTH(8), .DEPTH(RING_SIZE)) u_line_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tle_back #(.RING_SIZE(RING_SIZE)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head      (q_head),
    .q_pop     (q_pop),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .out_if    (out_if),
    .stat      (back_stat)
  );

  // Checks
  `TLE_ASSERT_IMPL(a_busy_has_work, clk, rst_n, rd_busy, !q_empty || !back_stat.idle, "read lock with no pending read")
  `TLE_ASSERT_IMPL(a_no_write_in_read, clk, rst_n, mem_re, !mem_we, "line write during read")

endmodule

`default_nettype wire

/* design/tle_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* design/tle_fifo.sv */
// Short command queue between the front and back ends.
`default_nettype none

module tle_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire tle_pkg::tle_cmd_t push_cmd,
  input  wire logic              pop,
  output tle_pkg::tle_cmd_t      head,
  output logic                   full,
  output logic                   empty
);
  import tle_pkg::*;

  tle_cmd_t         ent_r [Q_DEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == (QAW+1)'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = ent_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + QAW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + QAW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + (QAW+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

/* design/tle_front.sv */
// Front end: accepts request items, edits the ring state, queues commands.
`default_nettype none
`include "terminal_line_editor_unit_assert.svh"

module tle_front #(
  parameter int RING_SIZE = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       echo_en,
  tle_in_if.sink                          in_if,
  input  wire logic                       q_full,
  output logic                            q_push,
  output tle_pkg::tle_cmd_t               q_cmd,
  input  wire tle_pkg::tle_back_stat_t    back_stat,
  output logic                            mem_we,
  output logic [$clog2(RING_SIZE)-1:0]    mem_waddr,
  output logic [7:0]                      mem_wdata,
  output logic                            rd_busy
);
  import tle_pkg::*;

  localparam int AW = $clog2(RING_SIZE);

  logic [AW-1:0] start_r, start_nxt;
  logic [AW-1:0] len_r, len_nxt;
  logic          ready_r, ready_nxt;
  logic          busy_r, busy_nxt;

  logic          accept;
  logic [7:0]    ch_m;
  logic          is_rub;
  logic          len_nz;
  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail;
  logic [AW-1:0] start_inc;
  logic [AW-1:0] len_m1;
  logic [6:0]    maxc_m1;
  logic [7:0]    lw, mw, nmin;
  logic [5:0]    n6;
  logic          busy_set;

  assign in_if.ready = !q_full && !busy_r;
  assign accept      = in_if.valid && in_if.ready;
  assign rd_busy     = busy_r;

  // Classification and ring arithmetic
  always_comb begin
    ch_m      = (in_if.in_char == CH_CR) ? CH_LF : in_if.in_char;
    is_rub    = (ch_m == CH_BS) || (ch_m == CH_DEL);
    len_nz    = (len_r != '0);
    tail_sum  = {1'b0, start_r} + {1'b0, len_r};
    tail      = (tail_sum >= (AW+1)'(RING_SIZE)) ?
                AW'(tail_sum - (AW+1)'(RING_SIZE)) : tail_sum[AW-1:0];
    start_inc = (start_r == AW'(RING_SIZE - 1)) ? '0 : start_r + AW'(1);
    len_m1    = len_r - AW'(1);
    maxc_m1   = (in_if.max_chars == '0) ? 7'd0 : in_if.max_chars - 7'd1;
    lw        = 8'(len_m1);
    mw        = {1'b0, maxc_m1};
    nmin      = (lw < mw) ? lw : mw;
    if (!len_nz) begin
      n6 = 6'd0;
    end else if (nmin > 8'd63) begin
      n6 = 6'd63;
    end else begin
      n6 = nmin[5:0];
    end
  end

  // State update and command build
  always_comb begin
    start_nxt  = start_r;
    len_nxt    = len_r;
    ready_nxt  = ready_r;
    q_push     = 1'b0;
    mem_we     = 1'b0;
    busy_set   = 1'b0;
    q_cmd.op   = OP_ECHO;
    if (accept) begin
      case (req_t'(in_if.req_type))
        REQ_CHAR: begin
          if (is_rub) begin
            if (len_nz) begin
              len_nxt  = len_r - AW'(1);
              q_push   = 1'b1;
              q_cmd.op = OP_RUBOUT;
            end
          end else begin
            if (len_r != AW'(RING_SIZE - 1)) begin
              mem_we  = 1'b1;
              len_nxt = len_r + AW'(1);
            end
            if (ch_m == CH_LF) begin
              ready_nxt = 1'b1;
            end
            if (echo_en) begin
              q_push   = 1'b1;
              q_cmd.op = OP_ECHO;
            end
          end
        end
        REQ_POP: begin
          q_push = 1'b1;
          if (len_nz) begin
            q_cmd.op  = OP_POP;
            start_nxt = start_inc;
            len_nxt   = len_r - AW'(1);
            busy_set  = 1'b1;
          end else begin
            q_cmd.op = OP_POP_EMPTY;
          end
        end
        REQ_LINE: begin
          q_push    = 1'b1;
          start_nxt = tail;
          len_nxt   = '0;
          ready_nxt = 1'b0;
          if (n6 != '0) begin
            q_cmd.op = OP_LINE;
            busy_set = 1'b1;
          end else begin
            q_cmd.op = OP_LINE_EMPTY;
          end
        end
        default: begin
        end
      endcase
    end
    q_cmd.ch   = ch_m;
    q_cmd.addr = CMD_AW'(start_r);
    q_cmd.n    = n6;
    q_cmd.lr   = ready_nxt;
    q_cmd.blen = 6'(len_nxt);
  end

  assign mem_waddr = tail;
  assign mem_wdata = ch_m;

  // Read lock: set by a queued read, cleared when the back end finishes it
  always_comb begin
    busy_nxt = busy_r;
    if (busy_set) begin
      busy_nxt = 1'b1;
    end else if (back_stat.rd_done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      len_r   <= '0;
      ready_r <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      start_r <= start_nxt;
      len_r   <= len_nxt;
      ready_r <= ready_nxt;
      busy_r  <= busy_nxt;
    end
  end

  // Checks
  `TLE_ASSERT_IMPL(a_len_bound, clk, rst_n, 1'b1, len_r <= AW'(RING_SIZE - 1), "ring overfilled")
  `TLE_ASSERT_NEXT(a_line_clears, clk, rst_n, accept && (in_if.req_type == REQ_LINE), (len_r == '0) && !ready_r, "take line left state")

endmodule

`default_nettype wire

/* design/tle_back.sv */
// Back end: carries out queued commands and drives the result register.
`default_nettype none
`include "terminal_line_editor_unit_assert.svh"

module tle_back #(
  parameter int RING_SIZE = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     q_empty,
  input  wire tle_pkg::tle_cmd_t        head,
  output logic                          q_pop,
  output logic                          mem_re,
  output logic [$clog2(RING_SIZE)-1:0]  mem_raddr,
  input  wire logic [7:0]               mem_rdata,
  tle_out_if.source                     out_if,
  output tle_pkg::tle_back_stat_t       stat
);
  import tle_pkg::*;

  localparam int AW = $clog2(RING_SIZE);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EMIT = 3'b010,
    S_DATA = 3'b100
  } bst_t;

  bst_t          state_r, state_nxt;
  tle_cmd_t      cur_r, cur_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic [AW-1:0] addr_inc;

  logic          out_v_r, out_v_nxt;
  kind_t         kind_r, kind_nxt;
  logic [7:0]    char_r, char_nxt;
  logic          cval_r, cval_nxt;
  logic          last_r, last_nxt;
  logic [5:0]    lcnt_r, lcnt_nxt;
  logic          lr_r, lr_nxt;
  logic [5:0]    blen_r, blen_nxt;

  logic          out_free;
  logic          load;
  logic          fin;

  assign out_free = !out_v_r || out_if.ready;
  assign addr_inc = (rd_addr_r == AW'(RING_SIZE - 1)) ? '0 : rd_addr_r + AW'(1);

  // Command sequencer
  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    cnt_nxt     = cnt_r;
    rd_addr_nxt = rd_addr_r;
    q_pop       = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = rd_addr_r;
    load        = 1'b0;
    fin         = 1'b0;
    stat.idle   = (state_r == S_IDLE);
    stat.rd_done = 1'b0;
    kind_nxt    = kind_r;
    char_nxt    = char_r;
    cval_nxt    = cval_r;
    last_nxt    = last_r;
    lcnt_nxt    = lcnt_r;
    lr_nxt      = cur_r.lr;
    blen_nxt    = cur_r.blen;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cur_nxt = head;
          cnt_nxt = '0;
          if ((head.op == OP_POP) || (head.op == OP_LINE)) begin
            mem_re      = 1'b1;
            mem_raddr   = head.addr[AW-1:0];
            rd_addr_nxt = head.addr[AW-1:0];
            state_nxt   = S_DATA;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          load     = 1'b1;
          lcnt_nxt = '0;
          case (cur_r.op)
            OP_ECHO: begin
              kind_nxt = KIND_ECHO;
              char_nxt = cur_r.ch;
              cval_nxt = 1'b1;
              fin      = 1'b1;
            end
            OP_RUBOUT: begin
              // backspace, space, backspace
              kind_nxt = KIND_ECHO;
              char_nxt = (cnt_r == 6'd1) ? CH_SP : CH_BS;
              cval_nxt = 1'b1;
              fin      = (cnt_r == 6'd2);
            end
            OP_POP_EMPTY: begin
              kind_nxt = KIND_POP;
              char_nxt = 8'd0;
              cval_nxt = 1'b0;
              fin      = 1'b1;
            end
            default: begin
              kind_nxt = KIND_LINE;
              char_nxt = 8'd0;
              cval_nxt = 1'b0;
              fin      = 1'b1;
            end
          endcase
          last_nxt = fin;
          if (fin) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt = cnt_r + 6'd1;
          end
        end
      end
      S_DATA: begin
        if (out_free) begin
          load     = 1'b1;
          char_nxt = mem_rdata;
          cval_nxt = 1'b1;
          if (cur_r.op == OP_POP) begin
            kind_nxt = KIND_POP;
            lcnt_nxt = '0;
            fin      = 1'b1;
          end else begin
            kind_nxt = KIND_LINE;
            lcnt_nxt = cur_r.n;
            fin      = (cnt_r == cur_r.n - 6'd1);
          end
          last_nxt = fin;
          if (fin) begin
            state_nxt    = S_IDLE;
            stat.rd_done = 1'b1;
          end else begin
            // next character of the line
            mem_re      = 1'b1;
            mem_raddr   = addr_inc;
            rd_addr_nxt = addr_inc;
            cnt_nxt     = cnt_r + 6'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result register valid
  always_comb begin
    out_v_nxt = out_v_r && !out_if.ready;
    if (load) begin
      out_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    cnt_r     <= cnt_nxt;
    rd_addr_r <= rd_addr_nxt;
    if (load) begin
      kind_r <= kind_nxt;
      char_r <= char_nxt;
      cval_r <= cval_nxt;
      last_r <= last_nxt;
      lcnt_r <= lcnt_nxt;
      lr_r   <= lr_nxt;
      blen_r <= blen_nxt;
    end
  end

  assign out_if.valid        = out_v_r;
  assign out_if.out_kind     = kind_r;
  assign out_if.out_char     = char_r;
  assign out_if.out_valid    = cval_r;
  assign out_if.last         = last_r;
  assign out_if.line_count   = lcnt_r;
  assign out_if.line_ready   = lr_r;
  assign out_if.buffered_len = blen_r;

  // Checks
  `TLE_ASSERT_IMPL(a_data_op, clk, rst_n, state_r == S_DATA, (cur_r.op == OP_POP) || ((cur_r.op == OP_LINE) && (cnt_r < cur_r.n)), "bad read command")
  `TLE_ASSERT_IMPL(a_rubout_cnt, clk, rst_n, (state_r == S_EMIT) && (cnt_r != 6'd0), (cur_r.op == OP_RUBOUT) && (cnt_r < 6'd3), "echo sequence overrun")

endmodule

`default_nettype wire

/* bench/terminal_line_editor_unit_checker.sv */
// Result checker for the line editor: watches both channels and the register port.
module line_editor_checker #(
  parameter int RING_SIZE = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  tle_in_if           req_mon,
  tle_out_if          res_mon,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          fail_count,
  output int          pending,
  output int          matched
);
  timeunit 1ns;
  timeprecision 1ps;

  import tle_pkg::*;

  localparam logic [2:0] ECHO_ADDR = {REG_IDX_ECHO, 2'b00};
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic       real_char;
    logic       last;
    logic [5:0] count;
    logic       lr;
    logic [5:0] blen;
  } editor_result_t;

  // Shadow copy of the ring, the line flag and the echo register
  logic [7:0]     line_mem [RING_SIZE];
  int             head;
  int             held;
  logic           line_flag;
  logic           echo_on;
  editor_result_t expected_q[$];

  // Queue one expected result, stamped with the state after the step
  function automatic void expect_result(kind_t k, logic [7:0] c, logic v, int cnt, logic lst);
    editor_result_t r;
    r.kind      = k;
    r.ch        = c;
    r.real_char = v;
    r.last      = lst;
    r.count     = 6'(cnt);
    r.lr        = line_flag;
    r.blen      = 6'(held);
    expected_q.push_back(r);
  endfunction

  // Advance the shadow state by one accepted item and queue its results
  function automatic void predict_request(logic [1:0] req, logic [7:0] ch_in, logic [6:0] max_in);
    logic [7:0] ch;
    int         limit;
    int         n;
    int         first;
    logic [7:0] c;
    case (req)
      REQ_CHAR: begin
        ch = (ch_in == CH_CR) ? CH_LF : ch_in;
        if (ch == CH_BS || ch == CH_DEL) begin
          // rubout only when something is held
          if (held > 0) begin
            held--;
            expect_result(KIND_ECHO, CH_BS, 1'b1, 0, 1'b0);
            expect_result(KIND_ECHO, CH_SP, 1'b1, 0, 1'b0);
            expect_result(KIND_ECHO, CH_BS, 1'b1, 0, 1'b1);
          end
        end else begin
          // full ring drops the character but still echoes it when echo is on
          if (held < RING_SIZE - 1) begin
            line_mem[(head + held) % RING_SIZE] = ch;
            held++;
          end
          if (ch == CH_LF) line_flag = 1'b1;
          if (echo_on) expect_result(KIND_ECHO, ch, 1'b1, 0, 1'b1);
        end
      end
      REQ_POP: begin
        if (held > 0) begin
          c    = line_mem[head];
          head = (head + 1) % RING_SIZE;
          held--;
          expect_result(KIND_POP, c, 1'b1, 0, 1'b1);
        end else begin
          expect_result(KIND_POP, 8'h00, 1'b0, 0, 1'b1);
        end
      end
      REQ_LINE: begin
        limit = (max_in == 7'd0) ? 1 : int'(max_in);
        n     = 0;
        first = head;
        if (held > 0) begin
          n = held - 1;
          if (limit - 1 < n) n = limit - 1;
          if (n > 63) n = 63;
        end
        // the whole line is consumed whatever was returned
        head      = (head + held) % RING_SIZE;
        held      = 0;
        line_flag = 1'b0;
        if (n == 0) begin
          expect_result(KIND_LINE, 8'h00, 1'b0, 0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++)
            expect_result(KIND_LINE, line_mem[(first + i) % RING_SIZE], 1'b1, n, i == n - 1);
        end
      end
      default: ;
    endcase
  endfunction

  // Compare one accepted result with the oldest expectation
  function automatic void check_result();
    editor_result_t got;
    editor_result_t want;
    logic           bad;
    got.kind      = kind_t'(res_mon.out_kind);
    got.ch        = res_mon.out_char;
    got.real_char = res_mon.out_valid;
    got.last      = res_mon.last;
    got.count     = res_mon.line_count;
    got.lr        = res_mon.line_ready;
    got.blen      = res_mon.buffered_len;
    if (expected_q.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: result with nothing expected: kind=%0d char=%02h valid=%b last=%b",
                 $realtime, got.kind, got.ch, got.real_char, got.last);
      return;
    end
    want = expected_q.pop_front();
    bad  = (got.kind !== want.kind) || (got.ch !== want.ch) ||
           (got.real_char !== want.real_char) || (got.last !== want.last) ||
           (got.count !== want.count) || (got.lr !== want.lr) || (got.blen !== want.blen);
    if (bad) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("%0t: result mismatch", $realtime);
        $display("  expected kind=%0d char=%02h valid=%b last=%b count=%0d ready=%b len=%0d",
                 want.kind, want.ch, want.real_char, want.last, want.count, want.lr,
                 want.blen);
        $display("  actual   kind=%0d char=%02h valid=%b last=%b count=%0d ready=%b len=%0d",
                 got.kind, got.ch, got.real_char, got.last, got.count, got.lr, got.blen);
      end
    end else begin
      matched++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      head       = 0;
      held       = 0;
      line_flag  = 1'b0;
      echo_on    = 1'b0;
      fail_count = 0;
      matched    = 0;
      expected_q.delete();
    end else begin
      if (res_mon.valid && res_mon.ready) check_result();
      if (req_mon.valid && req_mon.ready)
        predict_request(req_mon.req_type, req_mon.in_char, req_mon.max_chars);
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == ECHO_ADDR)
        echo_on = cfg_pwdata[0];
    end
    pending = expected_q.size();
  end

endmodule

/* bench/terminal_line_editor_unit_tb.sv */
// Testbench top for the line editor: stimulus, register writes and verdict.
module terminal_line_editor_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tle_pkg::*;

  localparam int         RING_SIZE     = 64;
  localparam int         STALL_LIMIT   = 2000;
  localparam int         SETTLE_CYCLES = 16;
  localparam int         PHASE_ITEMS   = 88;
  localparam logic [2:0] ECHO_ADDR     = {REG_IDX_ECHO, 2'b00};
  localparam logic [1:0] REQ_UNUSED    = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count;
  int pending;
  int matched;
  int sent         = 0;
  int pops         = 0;
  int line_takes   = 0;
  int echo_writes  = 0;
  int phase_items  = 0;
  int quiet_cycles = 0;
  int in_burst     = 0;
  int out_burst    = 0;

  tle_in_if  req_ch ();
  tle_out_if res_ch ();

  terminal_line_editor_unit #(.RING_SIZE(RING_SIZE)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (req_ch),
    .out_if      (res_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  line_editor_checker #(.RING_SIZE(RING_SIZE)) line_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_mon     (req_ch),
    .res_mon     (res_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .fail_count  (fail_count),
    .pending     (pending),
    .matched     (matched)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: give up when no item moves for too long
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Wait before the next item; occasionally a run of back-to-back items
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) burst = $urandom_range(8, 30);
    return $urandom_range(0, 6);
  endfunction

  // Result side: random stall before taking each item
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = draw_gap(out_burst);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && res_ch.valid === 1'b1));
      @(negedge clk);
    end
  end

  // Offer one request and hold it until taken
  task automatic send_item(input logic [1:0] r, input logic [7:0] c, input logic [6:0] m);
    int gap;
    gap = draw_gap(in_burst);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= r;
    req_ch.in_char   <= c;
    req_ch.max_chars <= m;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    @(negedge clk);
    sent++;
    if (r != REQ_UNUSED) phase_items++;
    if (r == REQ_POP) pops++;
    if (r == REQ_LINE) line_takes++;
  endtask

  // Let every expected result drain, then let the pipeline go quiet
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Setup and access phase of a register write
  task automatic write_echo(input logic e);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ECHO_ADDR;
    cfg_pwdata  <= {31'd0, e};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    echo_writes++;
  endtask

  // Caller buffer size, mostly in range, sometimes zero or oversized
  function automatic logic [6:0] pick_max();
    case ($urandom_range(0, 9))
      0:       return 7'($urandom_range(65, 127));
      1:       return 7'd0;
      2:       return 7'd1;
      default: return 7'($urandom_range(1, 64));
    endcase
  endfunction

  // Typed character with some rubouts and raw bytes mixed in
  function automatic logic [7:0] line_char();
    case ($urandom_range(0, 19))
      0, 1:    return CH_BS;
      2:       return CH_DEL;
      3, 4:    return 8'($urandom);
      default: return 8'($urandom_range(8'h20, 8'h7e));
    endcase
  endfunction

  task automatic type_line(input int len, input bit edits, input bit terminate);
    for (int i = 0; i < len; i++)
      send_item(REQ_CHAR, edits ? line_char() : 8'($urandom_range(8'h20, 8'h7e)),
                7'($urandom));
    if (terminate)
      send_item(REQ_CHAR, $urandom_range(0, 1) ? CH_CR : CH_LF, 7'($urandom));
  endtask

  // Consume a line either in one take or by single pops
  task automatic consume_line(input int len);
    if ($urandom_range(0, 2) != 0)
      send_item(REQ_LINE, 8'($urandom), pick_max());
    else
      repeat ($urandom_range(1, len + 2)) send_item(REQ_POP, 8'($urandom), 7'($urandom));
  endtask

  task automatic run_phase(input int quota, input bit open_long);
    int len;
    phase_items = 0;
    // one line long enough to fill the ring and drop characters
    if (open_long) begin
      type_line($urandom_range(64, 72), 1'b0, 1'b1);
      consume_line(64);
    end
    while (phase_items < quota) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          len = ($urandom_range(0, 11) == 0) ? $urandom_range(56, 72) : $urandom_range(0, 12);
          type_line(len, len < 40, 1'b1);
          consume_line(len);
        end
        6, 7: begin
          repeat ($urandom_range(1, 6))
            send_item(2'($urandom_range(0, 3)), 8'($urandom), 7'($urandom));
        end
        8: begin
          repeat ($urandom_range(1, 4)) send_item(REQ_POP, 8'($urandom), 7'($urandom));
        end
        default: begin
          // take without a finished line
          type_line($urandom_range(1, 8), 1'b1, 1'b0);
          send_item(REQ_LINE, 8'($urandom), pick_max());
        end
      endcase
    end
  endtask

  initial begin
    req_ch.valid     = 1'b0;
    req_ch.req_type  = REQ_CHAR;
    req_ch.in_char   = 8'h00;
    req_ch.max_chars = 7'd0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = 3'd0;
    cfg_pwdata       = 32'd0;
    rst_n            = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part with echo on
    write_echo(1'b1);
    send_item(REQ_POP, 8'h00, 7'd0);       // pop with nothing held
    send_item(REQ_LINE, 8'h00, 7'd5);      // take on an empty ring
    send_item(REQ_CHAR, CH_BS, 7'd0);      // rubout with nothing held
    send_item(REQ_CHAR, 8'h61, 7'd127);
    send_item(REQ_CHAR, 8'h00, 7'd0);
    send_item(REQ_CHAR, 8'hff, 7'd64);
    send_item(REQ_CHAR, CH_DEL, 7'd0);     // rubout removes the newest
    send_item(REQ_CHAR, CH_CR, 7'd0);      // carriage return becomes newline
    send_item(REQ_POP, 8'hff, 7'd127);
    send_item(REQ_LINE, 8'h00, 7'd0);      // zero buffer size acts as one
    send_item(REQ_CHAR, 8'h68, 7'd0);
    send_item(REQ_CHAR, 8'h69, 7'd0);
    send_item(REQ_CHAR, CH_LF, 7'd0);
    send_item(REQ_LINE, 8'h00, 7'd64);
    send_item(REQ_CHAR, 8'h78, 7'd0);
    send_item(REQ_CHAR, 8'h79, 7'd0);
    send_item(REQ_CHAR, 8'h7a, 7'd0);
    send_item(REQ_CHAR, CH_CR, 7'd0);
    send_item(REQ_LINE, 8'h00, 7'd2);      // caller buffer shorter than line
    send_item(REQ_UNUSED, 8'h55, 7'd33);   // ignored request
    send_item(REQ_CHAR, 8'h71, 7'd0);
    send_item(REQ_CHAR, CH_BS, 7'd0);
    send_item(REQ_LINE, 8'h00, 7'd127);
    send_item(REQ_CHAR, CH_LF, 7'd0);
    send_item(REQ_LINE, 8'h00, 7'd1);
    settle();

    // Random part across echo settings
    write_echo(1'b0);
    run_phase(PHASE_ITEMS, 1'b0);
    settle();
    write_echo(1'b1);
    run_phase(PHASE_ITEMS, 1'b1);
    settle();
    write_echo(1'b0);
    run_phase(PHASE_ITEMS, 1'b0);
    settle();
    write_echo(1'b1);
    run_phase(PHASE_ITEMS, 1'b0);
    settle();

    if (pending != 0) $display("%0d expected results never arrived", pending);
    $display("Sent %0d requests (%0d pops, %0d line takes) across %0d echo register writes.",
             sent, pops, line_takes, echo_writes);
    $display("Matched %0d result items; %0d mismatches.", matched, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
